// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL, clocked on clk_i, reset by rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset
`define HCFM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Expression must never be true outside reset
`define HCFM_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define HCFM_ASSERT(lbl, prop, msg)
`define HCFM_NEVER(lbl, expr, msg)
`endif
`endif

// ===== hw/rtl/hcfm_pkg.sv =====
// ----------------------------------------------------------------------------
// hcfm_pkg
// Types, sizes and constants of the hashed context frequency model.
// ----------------------------------------------------------------------------
package hcfm_pkg;

  localparam int MAX_ORDER  = 4;
  localparam int SYMBOLS    = 256;
  localparam int CONTEXTS   = 256;

  localparam int CNT_W      = 16;
  localparam int SYM_W      = 8;
  localparam int CTX_W      = 8;
  localparam int ADDR_W     = CTX_W + SYM_W;
  localparam int ORD_W      = 3;
  localparam int LIMIT_W    = 17;
  localparam int HIDX_W     = $clog2(MAX_ORDER);
  localparam int CMD_W      = 2;
  localparam int CFG_IDX_W  = 1;

  // Low byte of FNV-1a offset and prime; the low hash byte depends on no other bits
  localparam logic [7:0] FNV_OFFSET_LO = 8'hC5;
  localparam logic [7:0] FNV_PRIME_LO  = 8'h93;

  localparam logic [SYM_W-1:0] DECODE_MISS = 8'hFF;
  localparam logic [SYM_W-1:0] SYM_LAST    = SYM_W'(SYMBOLS - 1);

  // Commands
  localparam logic [CMD_W-1:0] CMD_STATS  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DECODE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ORDER = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 1'b1;

  typedef logic [SYM_W-1:0] hist_t [MAX_ORDER];

  typedef struct packed {
    logic             done;
    logic [CTX_W-1:0] ctx;
  } hash_st_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_TOT_RD,
    ST_TOT_CHK,
    ST_SCAN_RD,
    ST_SCAN_ACC,
    ST_SCL_RD,
    ST_SCL_ACC,
    ST_INC_RD,
    ST_INC_ACC,
    ST_TOT_WR,
    ST_REHASH,
    ST_FIN_RD,
    ST_FIN
  } state_e;

endpackage

// ===== hw/rtl/hashed_context_frequency_model_unit.sv =====
// Stats and decode scan the context row from symbol zero; an update adds two to
// the count and the total, first halving the row if the new total would reach the limit.
// One item at a time: the next is accepted only once the last result is loaded for output.
// The hash walks the history bytes of the configured order (1 to 4), then raises done.
// After reset a clearing pass sets every count to one and every total to 256;
// no item is accepted meanwhile, configuration writes are taken.
// ----------------------------------------------------------------------------
// hashed_context_frequency_model_unit
// Adaptive order-N context model: stats, decode and update over hashed contexts.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module hashed_context_frequency_model_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [hcfm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [hcfm_pkg::LIMIT_W-1:0]   cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [hcfm_pkg::CMD_W-1:0]     cmd_i,
  input  logic [hcfm_pkg::SYM_W-1:0]     symbol_in_i,
  input  logic [hcfm_pkg::CNT_W-1:0]     target_count_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [hcfm_pkg::CNT_W-1:0]     cum_low_o,
  output logic [hcfm_pkg::CNT_W-1:0]     cum_high_o,
  output logic [hcfm_pkg::CNT_W-1:0]     context_total_o,
  output logic [hcfm_pkg::SYM_W-1:0]     decoded_symbol_o
);
  import hcfm_pkg::*;

  state_e            state_q, state_d;
  logic [ORD_W-1:0]  order_q;
  logic [LIMIT_W-1:0] limit_q;
  logic [ORD_W-1:0]  order_n;
  hist_t             hist_q;
  logic              hist_shift;

  logic [ADDR_W-1:0] clr_q, clr_d;
  logic [CMD_W-1:0]  cmd_q, cmd_d;
  logic [SYM_W-1:0]  sym_q, sym_d;
  logic [CNT_W-1:0]  tgt_q, tgt_d;
  logic [CTX_W-1:0]  ctx_q, ctx_d;
  logic [SYM_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  acc_q, acc_d;
  logic [CNT_W-1:0]  tot_q, tot_d;
  logic [CNT_W-1:0]  lo_q, lo_d, hi_q, hi_d;
  logic [SYM_W-1:0]  dec_q, dec_d;

  logic              out_valid_q, out_valid_d;
  logic [CNT_W-1:0]  out_lo_q, out_hi_q, out_tot_q;
  logic [SYM_W-1:0]  out_dec_q;
  logic              out_load;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  logic [CNT_W-1:0]  mem_wdata, mem_rdata;

  logic [CNT_W-1:0]  tot_mem [CONTEXTS];
  logic [CNT_W-1:0]  tot_rd_q;
  logic              tot_we;
  logic [CTX_W-1:0]  tot_waddr;
  logic [CNT_W-1:0]  tot_wdata;

  logic              hash_start;
  hash_st_t          hash_st;

  logic [CNT_W-1:0]  add_a, add_b;
  logic [CNT_W:0]    add_sum;
  logic [CNT_W-1:0]  halved;

  // Clamp the order to one .. MAX_ORDER
  always_comb begin
    order_n = order_q;
    if (order_q == '0) begin
      order_n = ORD_W'(1);
    end else if (order_q > ORD_W'(MAX_ORDER)) begin
      order_n = ORD_W'(MAX_ORDER);
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= ORD_W'(1);
      limit_q <= LIMIT_W'(65536);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ORDER: order_q <= cfg_data_i[ORD_W-1:0];
        REG_LIMIT: limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Shift the symbol into the first order_n history bytes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_ORDER; i++) hist_q[i] <= '0;
    end else if (hist_shift) begin
      hist_q[0] <= sym_q;
      for (int i = 1; i < MAX_ORDER; i++) begin
        if (ORD_W'(i) < order_n) hist_q[i] <= hist_q[i-1];
      end
    end
  end

  hcfm_hash u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hash_start),
    .order_i (order_n),
    .hist_i  (hist_q),
    .st_o    (hash_st)
  );

  hcfm_count_mem u_counts (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // Context totals: one write, one registered read at the current context
  always_ff @(posedge clk_i) begin
    if (tot_we) begin
      tot_mem[tot_waddr] <= tot_wdata;
    end
    tot_rd_q <= tot_mem[ctx_q];
  end

  // Shared adder and halving of the count under scan
  assign halved  = (mem_rdata >> 1) | CNT_W'(1);
  assign add_sum = {1'b0, add_a} + {1'b0, add_b};

  always_comb begin
    add_a = acc_q;
    add_b = mem_rdata;
    unique case (state_q)
      ST_TOT_CHK: begin
        add_a = tot_rd_q;
        add_b = CNT_W'(2);
      end
      ST_SCL_ACC: add_b = halved;
      ST_INC_ACC: begin
        add_a = mem_rdata;
        add_b = CNT_W'(2);
      end
      ST_TOT_WR: begin
        add_a = tot_q;
        add_b = CNT_W'(2);
      end
      default: ;
    endcase
  end

  // Sequencer
  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    cmd_d      = cmd_q;
    sym_d      = sym_q;
    tgt_d      = tgt_q;
    ctx_d      = ctx_q;
    idx_d      = idx_q;
    acc_d      = acc_q;
    tot_d      = tot_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    dec_d      = dec_q;
    in_ready_o = 1'b0;
    hash_start = 1'b0;
    hist_shift = 1'b0;
    mem_we     = 1'b0;
    mem_addr   = {ctx_q, idx_q};
    mem_wdata  = add_sum[CNT_W-1:0];
    tot_we     = 1'b0;
    tot_waddr  = ctx_q;
    tot_wdata  = tot_q;
    out_load   = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_q;
        mem_wdata = CNT_W'(1);
        tot_we    = 1'b1;
        tot_waddr = clr_q[CTX_W-1:0];
        tot_wdata = CNT_W'(SYMBOLS);
        clr_d     = clr_q + ADDR_W'(1);
        if (clr_q == '1) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_d      = cmd_i;
          sym_d      = symbol_in_i;
          tgt_d      = target_count_i;
          lo_d       = '0;
          hi_d       = '0;
          dec_d      = '0;
          hash_start = 1'b1;
          state_d    = ST_HASH;
        end
      end
      ST_HASH: begin
        if (hash_st.done) begin
          ctx_d = hash_st.ctx;
          idx_d = '0;
          acc_d = '0;
          case (cmd_q) inside
            CMD_STATS, CMD_DECODE: state_d = ST_SCAN_RD;
            CMD_UPDATE:            state_d = ST_TOT_RD;
            default:               state_d = ST_FIN_RD;
          endcase
        end
      end
      ST_TOT_RD: state_d = ST_TOT_CHK;
      ST_TOT_CHK: begin
        tot_d = tot_rd_q;
        if (add_sum >= limit_q) state_d = ST_SCL_RD;
        else                    state_d = ST_INC_RD;
      end
      ST_SCAN_RD: state_d = ST_SCAN_ACC;
      ST_SCAN_ACC: begin
        state_d = ST_SCAN_RD;
        acc_d   = add_sum[CNT_W-1:0];
        idx_d   = idx_q + SYM_W'(1);
        if (cmd_q == CMD_STATS) begin
          if (idx_q == sym_q) begin
            lo_d    = acc_q;
            hi_d    = add_sum[CNT_W-1:0];
            state_d = ST_FIN_RD;
          end
        end else if (tgt_q < add_sum[CNT_W-1:0]) begin
          dec_d   = idx_q;
          state_d = ST_FIN_RD;
        end else if (idx_q == SYM_LAST) begin
          dec_d   = DECODE_MISS;
          state_d = ST_FIN_RD;
        end
      end
      ST_SCL_RD: state_d = ST_SCL_ACC;
      ST_SCL_ACC: begin
        mem_we    = 1'b1;
        mem_wdata = halved;
        acc_d     = add_sum[CNT_W-1:0];
        idx_d     = idx_q + SYM_W'(1);
        state_d   = ST_SCL_RD;
        if (idx_q == SYM_LAST) begin
          tot_d   = add_sum[CNT_W-1:0];
          state_d = ST_INC_RD;
        end
      end
      ST_INC_RD: begin
        mem_addr = {ctx_q, sym_q};
        state_d  = ST_INC_ACC;
      end
      ST_INC_ACC: begin
        mem_addr = {ctx_q, sym_q};
        mem_we   = 1'b1;
        state_d  = ST_TOT_WR;
      end
      ST_TOT_WR: begin
        tot_we     = 1'b1;
        tot_wdata  = add_sum[CNT_W-1:0];
        hist_shift = 1'b1;
        hash_start = 1'b1;
        state_d    = ST_REHASH;
      end
      ST_REHASH: begin
        if (hash_st.done) begin
          ctx_d   = hash_st.ctx;
          state_d = ST_FIN_RD;
        end
      end
      ST_FIN_RD: state_d = ST_FIN;
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    sym_q <= sym_d;
    tgt_q <= tgt_d;
    ctx_q <= ctx_d;
    idx_q <= idx_d;
    acc_q <= acc_d;
    tot_q <= tot_d;
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    dec_q <= dec_d;
  end

  // Output register: hold the item until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (out_load)    out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_lo_q  <= lo_q;
      out_hi_q  <= hi_q;
      out_tot_q <= tot_rd_q;
      out_dec_q <= dec_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign cum_low_o        = out_lo_q;
  assign cum_high_o       = out_hi_q;
  assign context_total_o  = out_tot_q;
  assign decoded_symbol_o = out_dec_q;

  `HCFM_ASSERT(a_busy_after_accept, (in_valid_i && in_ready_o) |=> !in_ready_o, "ready after accept")
  `HCFM_NEVER(a_no_item_in_clear, (state_q == ST_CLEAR) && (in_ready_o || out_valid_q), "item during clear")
  `HCFM_ASSERT(a_write_in_row, (mem_we && state_q != ST_CLEAR) |-> (mem_addr[ADDR_W-1:SYM_W] == ctx_q), "write outside context row")

endmodule

// ===== hw/rtl/hcfm_count_mem.sv =====
// ----------------------------------------------------------------------------
// hcfm_count_mem
// Single-port count memory, one row of counts per context, registered read.
// ----------------------------------------------------------------------------
module hcfm_count_mem (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [hcfm_pkg::ADDR_W-1:0] addr_i,
  input  logic [hcfm_pkg::CNT_W-1:0]  wdata_i,
  output logic [hcfm_pkg::CNT_W-1:0]  rdata_o
);
  import hcfm_pkg::*;

  logic [CNT_W-1:0] mem [CONTEXTS*SYMBOLS];
  logic [CNT_W-1:0] rdata_q;

  // Write and read one entry per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/hcfm_hash.sv =====
// ----------------------------------------------------------------------------
// hcfm_hash
// Iterative FNV-1a over the history, one byte per cycle, low byte kept.
// ----------------------------------------------------------------------------
module hcfm_hash (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [hcfm_pkg::ORD_W-1:0] order_i,
  input  hcfm_pkg::hist_t            hist_i,
  output hcfm_pkg::hash_st_t         st_o
);
  import hcfm_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [HIDX_W-1:0] k_q, k_d;
  logic [7:0]        h_q, h_d;
  logic [15:0]       prod;
  logic              last;

  assign prod = 16'(h_q ^ hist_i[k_q]) * 16'(FNV_PRIME_LO);
  assign last = ({1'b0, k_q} == (order_i - ORD_W'(1)));

  // Advance one history byte per cycle
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    k_d    = k_q;
    h_d    = h_q;
    if (start_i) begin
      busy_d = 1'b1;
      k_d    = '0;
      h_d    = FNV_OFFSET_LO;
    end else if (busy_q) begin
      h_d = prod[7:0];
      k_d = k_q + HIDX_W'(1);
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      k_q    <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      k_q    <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q <= h_d;
  end

  assign st_o.done = done_q;
  assign st_o.ctx  = CTX_W'(h_q);

endmodule
